/* sv/rrhc_pkg.sv */
// Package for the receive ring header checker: types, codes, constants.
// Used by every file of the block; depends on nothing.
`default_nettype none

package rrhc_pkg;

    // Ring page size in bytes (64..256, a power of two).
    localparam int unsigned PAGE_BYTES = 256;
    localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);

    localparam int unsigned PAGE_W = 8;
    localparam int unsigned STOP_W = 9;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 16;
    // Wide byte arithmetic: address plus length can pass 2**16.
    localparam int unsigned WIDE_W = 18;

    localparam logic [LEN_W-1:0] HDR_BYTES = LEN_W'(4);

    localparam logic [PAGE_W-1:0] RING_START_RESET = PAGE_W'(70);
    localparam logic [STOP_W-1:0] RING_STOP_RESET  = STOP_W'(128);
    localparam logic [LEN_W-1:0]  MIN_LEN_RESET    = LEN_W'(60);
    localparam logic [LEN_W-1:0]  MAX_LEN_RESET    = LEN_W'(1514);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RING_START = 4'd0,
        CFG_RING_STOP  = 4'd1,
        CFG_MIN_LEN    = 4'd2,
        CFG_MAX_LEN    = 4'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        VERDICT_EMPTY    = 3'd0,
        VERDICT_DELIVER  = 3'd1,
        VERDICT_BAD_LEN  = 3'd2,
        VERDICT_BAD_NEXT = 3'd3,
        VERDICT_MISMATCH = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [PAGE_W-1:0] ring_start_page;
        logic [STOP_W-1:0] ring_stop_page;
        logic [LEN_W-1:0]  min_payload_len;
        logic [LEN_W-1:0]  max_payload_len;
    } ring_cfg_t;

    typedef struct packed {
        logic [PAGE_W-1:0] write_page;
        logic [PAGE_W-1:0] header_next_page;
        logic [LEN_W-1:0]  header_total_len;
    } header_t;

    typedef struct packed {
        verdict_t          verdict;
        logic [PAGE_W-1:0] new_boundary_page;
        logic [LEN_W-1:0]  payload_addr;
        logic [LEN_W-1:0]  payload_len;
        logic [LEN_W-1:0]  first_part_len;
        logic [LEN_W-1:0]  second_part_addr;
        logic              wraps;
    } check_result_t;

endpackage

`default_nettype wire

/* sv/rrhc_if.sv */
// Channel interfaces: header requests in, check results out, register writes.
// Depends on rrhc_pkg.
`default_nettype none

interface rrhc_hdr_if
    import rrhc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] write_page;
    logic [PAGE_W-1:0] header_next_page;
    logic [LEN_W-1:0]  header_total_len;

    modport source (output valid, write_page, header_next_page, header_total_len,
                    input ready);
    modport sink   (input valid, write_page, header_next_page, header_total_len,
                    output ready);
endinterface

interface rrhc_res_if
    import rrhc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [2:0]        verdict;
    logic [PAGE_W-1:0] new_boundary_page;
    logic [LEN_W-1:0]  payload_addr;
    logic [LEN_W-1:0]  payload_len;
    logic [LEN_W-1:0]  first_part_len;
    logic [LEN_W-1:0]  second_part_addr;
    logic              wraps;

    modport source (output valid, verdict, new_boundary_page, payload_addr, payload_len,
                    first_part_len, second_part_addr, wraps,
                    input ready);
    modport sink   (input valid, verdict, new_boundary_page, payload_addr, payload_len,
                    first_part_len, second_part_addr, wraps,
                    output ready);
endinterface

interface rrhc_cfg_if
    import rrhc_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/rrhc_state.sv */
// Ring registers and the boundary page.
// Depends on rrhc_pkg.
`default_nettype none

module rrhc_state
    import rrhc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   bnd_we,
    input  wire logic [PAGE_W-1:0]      bnd_next,
    output ring_cfg_t                   cfg,
    output logic [PAGE_W-1:0]           boundary
);

    ring_cfg_t         cfg_reg;
    logic [PAGE_W-1:0] boundary_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ring_start_page <= RING_START_RESET;
            cfg_reg.ring_stop_page  <= RING_STOP_RESET;
            cfg_reg.min_payload_len <= MIN_LEN_RESET;
            cfg_reg.max_payload_len <= MAX_LEN_RESET;
            boundary_reg            <= RING_START_RESET;
        end
        else
        begin
            // The user must issue register writes only while idle (not enforced); a write wins over bnd_we.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RING_START:
                    begin
                        cfg_reg.ring_start_page <= cfg_data[PAGE_W-1:0];
                        boundary_reg            <= cfg_data[PAGE_W-1:0];
                    end
                    CFG_RING_STOP: cfg_reg.ring_stop_page  <= cfg_data[STOP_W-1:0];
                    CFG_MIN_LEN:   cfg_reg.min_payload_len <= cfg_data[LEN_W-1:0];
                    CFG_MAX_LEN:   cfg_reg.max_payload_len <= cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            else if (bnd_we)
            begin
                boundary_reg <= bnd_next;
            end
        end
    end

    assign cfg      = cfg_reg;
    assign boundary = boundary_reg;

endmodule

`default_nettype wire

/* sv/rrhc_check.sv */
// Single-pass header check: verdict, next boundary and payload segments.
// Depends on rrhc_pkg.
`default_nettype none

module rrhc_check
    import rrhc_pkg::*;
(
    input  wire ring_cfg_t         cfg,
    input  wire logic [PAGE_W-1:0] boundary,
    input  wire header_t           hdr,
    output check_result_t          res
);

    logic              next_in_ring;
    logic [PAGE_W-1:0] page_dist;
    logic [WIDE_W-1:0] pages_needed;
    logic              dist_ok;
    logic [LEN_W-1:0]  plen;
    logic              bad_len;
    logic [WIDE_W-1:0] addr_w;
    logic [WIDE_W-1:0] end_w;
    logic [WIDE_W-1:0] tail_w;
    logic              fits;

    always_comb
    begin
        next_in_ring = (hdr.header_next_page >= cfg.ring_start_page) &&
                       ({1'b0, hdr.header_next_page} < cfg.ring_stop_page);

        // Page distance, mod 256, wrapping through the ring end.
        if (boundary <= hdr.header_next_page)
            page_dist = hdr.header_next_page - boundary;
        else
            page_dist = cfg.ring_stop_page[PAGE_W-1:0] - cfg.ring_start_page
                        + hdr.header_next_page - boundary;

        // Both sides are whole pages, so compare in pages.
        pages_needed = (WIDE_W'(hdr.header_total_len) + WIDE_W'(HDR_BYTES)
                        + WIDE_W'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
        dist_ok = (WIDE_W'(page_dist) == pages_needed);

        plen    = hdr.header_total_len - HDR_BYTES;
        bad_len = (hdr.header_total_len < HDR_BYTES) ||
                  (plen < cfg.min_payload_len) || (plen > cfg.max_payload_len);

        addr_w = (WIDE_W'(boundary) << PAGE_SHIFT) + WIDE_W'(HDR_BYTES);
        end_w  = WIDE_W'(cfg.ring_stop_page) << PAGE_SHIFT;
        tail_w = addr_w + WIDE_W'(plen);
        fits   = (tail_w <= end_w);

        res.verdict           = VERDICT_EMPTY;
        res.new_boundary_page = boundary;
        res.payload_addr      = '0;
        res.payload_len       = '0;
        res.first_part_len    = '0;
        res.second_part_addr  = '0;
        res.wraps             = 1'b0;

        priority if (boundary == hdr.write_page)
        begin
            res.verdict = VERDICT_EMPTY;
        end
        else if (!next_in_ring)
        begin
            res.verdict           = VERDICT_BAD_NEXT;
            res.new_boundary_page = hdr.write_page;
        end
        else if (!dist_ok)
        begin
            res.verdict           = VERDICT_MISMATCH;
            res.new_boundary_page = hdr.write_page;
        end
        else if (bad_len)
        begin
            res.verdict           = VERDICT_BAD_LEN;
            res.new_boundary_page = hdr.header_next_page;
        end
        else
        begin
            res.verdict           = VERDICT_DELIVER;
            res.new_boundary_page = hdr.header_next_page;
            res.payload_addr      = addr_w[LEN_W-1:0];
            res.payload_len       = plen;
            if (fits)
            begin
                res.first_part_len = plen;
            end
            else
            begin
                // Boundary already past ring end: nothing before the wrap.
                res.first_part_len   = (addr_w >= end_w) ? '0 : LEN_W'(end_w - addr_w);
                res.second_part_addr =
                    LEN_W'(WIDE_W'(cfg.ring_start_page) << PAGE_SHIFT);
                res.wraps            = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/receive_ring_header_checker_unit.sv */
// Top level of the receive ring header checker.
// Depends on rrhc_pkg, rrhc_if, rrhc_state and rrhc_check.
//
// Takes one receive ring header request per clock unless rx_out stalls, and
// returns one result per request: an empty-ring report, a skipped bad-length
// packet, a ring flush (bad next page or page/length mismatch, boundary jumps
// to the write page), or a delivery with payload address, length and the split
// at the ring end. Throughput is one request per cycle while rx_out is ready.
// A taken request sits in the input register; its result is loaded into the
// result register once that register is free and shows on rx_out from then on.
// The boundary page is updated when a request leaves the input register, so the
// next request is always checked against the boundary left by the one before;
// that loop through the check logic sets the rate. Register writes on cfg are
// taken at once (ready stays high) and must only be issued while no request is
// in flight. Writing the ring start page also reloads the boundary.
`default_nettype none

module receive_ring_header_checker_unit
    import rrhc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rrhc_cfg_if.sink    cfg,
    rrhc_hdr_if.sink    rx_in,
    rrhc_res_if.source  rx_out
);

    ring_cfg_t         ring_cfg;
    logic [PAGE_W-1:0] boundary;

    // Input register.
    logic          hdr_valid_reg;
    header_t       hdr_reg;
    // Result register.
    logic          res_valid_reg;
    check_result_t res_reg;

    check_result_t res_next;
    logic          res_free;
    logic          hdr_advance;
    logic          hdr_take;

    assign cfg.ready = 1'b1;

    assign res_free    = !res_valid_reg || rx_out.ready;
    assign hdr_advance = hdr_valid_reg && res_free;
    assign rx_in.ready = !hdr_valid_reg || res_free;
    assign hdr_take    = rx_in.valid && rx_in.ready;

    rrhc_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .bnd_we    (hdr_advance),
        .bnd_next  (res_next.new_boundary_page),
        .cfg       (ring_cfg),
        .boundary  (boundary)
    );

    rrhc_check u_check (
        .cfg      (ring_cfg),
        .boundary (boundary),
        .hdr      (hdr_reg),
        .res      (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx_in.ready)
                hdr_valid_reg <= rx_in.valid;
            if (res_free)
                res_valid_reg <= hdr_valid_reg;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (hdr_take)
        begin
            hdr_reg.write_page       <= rx_in.write_page;
            hdr_reg.header_next_page <= rx_in.header_next_page;
            hdr_reg.header_total_len <= rx_in.header_total_len;
        end
        if (hdr_advance)
            res_reg <= res_next;
    end

    assign rx_out.valid             = res_valid_reg;
    assign rx_out.verdict           = res_reg.verdict;
    assign rx_out.new_boundary_page = res_reg.new_boundary_page;
    assign rx_out.payload_addr      = res_reg.payload_addr;
    assign rx_out.payload_len       = res_reg.payload_len;
    assign rx_out.first_part_len    = res_reg.first_part_len;
    assign rx_out.second_part_addr  = res_reg.second_part_addr;
    assign rx_out.wraps             = res_reg.wraps;

endmodule

`default_nettype wire
